### src/mcfd_pkg.sv
// Package for the multi-connection frame deframer: types, constants, substitution ROM.
// No dependencies.
`timescale 1ns / 1ps
package mcfd_pkg;
   localparam int CONNECTIONS = 16;
   localparam int CONN_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam logic [3:0] HDR_LAST = 4'd12;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_CLOSE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic       command;
      logic [3:0] connection;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [3:0]         out_connection;
      logic [7:0]         payload_byte;
      logic               first_of_frame;
      logic               last_of_frame;
      logic               frame_status;
      logic               framed_format;
      logic [15:0]        command_code;
      logic signed [7:0]  version_value;
      logic signed [7:0]  subversion_value;
      logic [15:0]        frame_length;
   } rsp_type;

   // per-connection context word held in the state memory
   typedef struct packed {
      logic [3:0]  header_index;
      logic [7:0]  first_byte_held;
      logic        format_flag;
      logic [15:0] payload_remaining;
      logic [15:0] length_store;
      logic [7:0]  running_sum;
      logic [7:0]  check_store;
      logic [15:0] cmd_store;
      logic [7:0]  version_store;
      logic [7:0]  subversion_store;
   } ctx_type;

   function automatic logic [7:0] subst(input logic [7:0] b);
      logic [7:0] rom [256];
      rom = '{
      8'h51,8'hA1,8'h9E,8'hB0,8'h1E,8'h83,8'h1C,8'h2D,8'hE9,8'h77,8'h3D,8'h13,8'h93,8'h10,8'h45,8'hFF,
      8'h6D,8'hC9,8'h20,8'h2F,8'h1B,8'h82,8'h1A,8'h7D,8'hF5,8'hCF,8'h52,8'hA8,8'hD2,8'hA4,8'hB4,8'h0B,
      8'h31,8'h97,8'h57,8'h19,8'h34,8'hDF,8'h5B,8'h41,8'h58,8'h49,8'hAA,8'h5F,8'h0A,8'hEF,8'h88,8'h01,
      8'hDC,8'h95,8'hD4,8'hAF,8'h7B,8'hE3,8'h11,8'h8E,8'h9D,8'h16,8'h61,8'h8C,8'h84,8'h3C,8'h1F,8'h5A,
      8'h02,8'h4F,8'h39,8'hFE,8'h04,8'h07,8'h5C,8'h8B,8'hEE,8'h66,8'h33,8'hC4,8'hC8,8'h59,8'hB5,8'h5D,
      8'hC2,8'h6C,8'hF6,8'h4D,8'hFB,8'hAE,8'h4A,8'h4B,8'hF3,8'h35,8'h2C,8'hCA,8'h21,8'h78,8'h3B,8'h03,
      8'hFD,8'h24,8'hBD,8'h25,8'h37,8'h29,8'hAC,8'h4E,8'hF9,8'h92,8'h3A,8'h32,8'h4C,8'hDA,8'h06,8'h5E,
      8'h00,8'h94,8'h60,8'hEC,8'h17,8'h98,8'hD7,8'h3E,8'hCB,8'h6A,8'hA9,8'hD9,8'h9C,8'hBB,8'h08,8'h8F,
      8'h40,8'hA0,8'h6F,8'h55,8'h67,8'h87,8'h54,8'h80,8'hB2,8'h36,8'h47,8'h22,8'h44,8'h63,8'h05,8'h6B,
      8'hF0,8'h0F,8'hC7,8'h90,8'hC5,8'h65,8'hE2,8'h64,8'hFA,8'hD5,8'hDB,8'h12,8'h7A,8'h0E,8'hD8,8'h7E,
      8'h99,8'hD1,8'hE8,8'hD6,8'h86,8'h27,8'hBF,8'hC1,8'h6E,8'hDE,8'h9A,8'h09,8'h0D,8'hAB,8'hE1,8'h91,
      8'h56,8'hCD,8'hB3,8'h76,8'h0C,8'hC3,8'hD3,8'h9F,8'h42,8'hB6,8'h9B,8'hE5,8'h23,8'hA7,8'hAD,8'h18,
      8'hC6,8'hF4,8'hB8,8'hBE,8'h15,8'h43,8'h70,8'hE0,8'hE7,8'hBC,8'hF1,8'hBA,8'hA5,8'hA6,8'h53,8'h75,
      8'hE4,8'hEB,8'hE6,8'h85,8'h14,8'h48,8'hDD,8'h38,8'h2A,8'hCC,8'h7F,8'hB1,8'hC0,8'h71,8'h96,8'hF8,
      8'h3F,8'h28,8'hF2,8'h69,8'h74,8'h68,8'hB7,8'hA3,8'h50,8'hD0,8'h79,8'h1D,8'hFC,8'hCE,8'h8A,8'h8D,
      8'h2E,8'h62,8'h30,8'hEA,8'hED,8'h2B,8'h26,8'hB9,8'h81,8'h7C,8'h46,8'h89,8'h73,8'hA2,8'hF7,8'h72};
      return rom[b];
   endfunction
endpackage

### src/mcfd_ctx_mem.sv
// Per-connection context memory with valid bits (entry not valid reads as zero).
// Depends on mcfd_pkg.
`timescale 1ns / 1ps
module mcfd_ctx_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [mcfd_pkg::CONN_W-1:0] rd_addr,
   output mcfd_pkg::ctx_type        rd_data,
   input  logic                     wr_en,
   input  logic [mcfd_pkg::CONN_W-1:0] wr_addr,
   input  mcfd_pkg::ctx_type        wr_data
);
   import mcfd_pkg::*;
   ctx_type                mem [CONNECTIONS];
   ctx_type                rd_raw_ff;
   logic                   rd_vld_ff;
   logic [CONNECTIONS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;
endmodule

### src/mcfd_step.sv
// Combinational frame step: updates one connection context for one item.
// Depends on mcfd_pkg.
`timescale 1ns / 1ps
module mcfd_step (
   input  mcfd_pkg::req_type ireq,
   input  mcfd_pkg::ctx_type ctx,
   output mcfd_pkg::ctx_type nctx,
   output logic              emit,
   output mcfd_pkg::rsp_type rsp
);
   import mcfd_pkg::*;
   logic       enc;
   logic [7:0] v;
   logic [7:0] sum;
   logic [15:0] rem;
   logic       m_ok;
   logic       fin;

   always_comb begin
      nctx = ctx;
      emit = 1'b0;
      fin  = 1'b0;
      rsp  = '0;
      enc  = ctx.format_flag && (ctx.check_store != 8'd0);
      v    = enc ? subst(ireq.data_byte) : ireq.data_byte;
      sum  = ctx.running_sum + v;
      rem  = ctx.payload_remaining - 16'd1;
      m_ok = (ctx.first_byte_held == 8'h4D || ctx.first_byte_held == 8'h6D) &&
             (ireq.data_byte == 8'h59 || ireq.data_byte == 8'h79);
      if (ireq.command) begin
         nctx = '0;
         emit = 1'b1;
         rsp.result_kind    = KIND_CLOSE;
         rsp.out_connection = ireq.connection;
      end else if (ctx.payload_remaining != 16'd0) begin
         emit = 1'b1;
         nctx.payload_remaining = rem;
         nctx.running_sum = (rem == 16'd0) ? 8'd0 : (enc ? sum : ctx.running_sum);
         rsp.result_kind    = KIND_PAYLOAD;
         rsp.payload_byte   = v;
         rsp.first_of_frame = (ctx.payload_remaining == ctx.length_store);
         rsp.last_of_frame  = (rem == 16'd0);
         rsp.frame_status   = (rem == 16'd0) && enc && ((sum + ctx.check_store) != 8'd0);
      end else if (ctx.header_index == 4'd0) begin
         nctx.first_byte_held = ireq.data_byte;
         nctx.header_index    = 4'd1;
      end else if (ctx.header_index == 4'd1) begin
         if (m_ok) begin
            nctx.format_flag  = 1'b1;
            nctx.header_index = 4'd2;
         end else begin
            nctx.format_flag      = 1'b0;
            nctx.cmd_store        = '0;
            nctx.version_store    = '0;
            nctx.subversion_store = '0;
            nctx.check_store      = '0;
            nctx.length_store     = {ctx.first_byte_held, ireq.data_byte};
            fin = 1'b1;
         end
      end else begin
         unique case (ctx.header_index)
            4'd2: nctx.cmd_store = {8'd0, ireq.data_byte};
            4'd3: nctx.cmd_store = {ireq.data_byte, ctx.cmd_store[7:0]};
            4'd4: nctx.version_store = ireq.data_byte;
            4'd5: nctx.subversion_store = ireq.data_byte;
            4'd6: nctx.length_store = {8'd0, ireq.data_byte};
            4'd7: nctx.length_store = {ireq.data_byte, ctx.length_store[7:0]};
            4'd8: nctx.check_store = ireq.data_byte;
            default: ;
         endcase
         if (ctx.header_index >= HDR_LAST) fin = 1'b1;
         else nctx.header_index = ctx.header_index + 4'd1;
      end
      if (fin) begin
         nctx.header_index      = 4'd0;
         nctx.running_sum       = 8'd0;
         nctx.payload_remaining = nctx.length_store;
         if (nctx.length_store == 16'd0) begin
            emit = 1'b1;
            rsp.result_kind    = KIND_EMPTY;
            rsp.first_of_frame = 1'b1;
            rsp.last_of_frame  = 1'b1;
            rsp.frame_status   = nctx.format_flag && (nctx.check_store != 8'd0);
         end
      end
      if (emit && !ireq.command) begin
         rsp.out_connection   = ireq.connection;
         rsp.framed_format    = nctx.format_flag;
         rsp.command_code     = nctx.cmd_store;
         rsp.version_value    = nctx.version_store;
         rsp.subversion_value = nctx.subversion_store;
         rsp.frame_length     = nctx.length_store;
      end
   end
endmodule

### src/multi_connection_frame_deframer.sv
// Top level of the multi-connection frame deframer.
// Depends on mcfd_pkg, mcfd_ctx_mem, mcfd_step.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | mcfd_pkg::req_type
//  rsp     | out | rsp_valid/rsp_ready | mcfd_pkg::rsp_type
//
// One item per cycle unless the result stalls; memory read, then step
// and write back into the output register. Back-to-back items on the same
// connection take the just-computed context by forwarding.
// Reset clears all contexts at once through the memory's valid bits.
// A stalled result stops the pipe; req_ready falls only while the output
// register is full and not being drained.
`timescale 1ns / 1ps
module multi_connection_frame_deframer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcfd_pkg::rsp_type rsp_data
);
   import mcfd_pkg::*;

   logic    s1_vld_ff;
   req_type s1_req_ff;
   logic    out_vld_ff;
   rsp_type out_ff;
   ctx_type fwd_ff;
   logic    fwd_vld_ff;
   logic [CONN_W-1:0] fwd_addr_ff;

   ctx_type rd_data, ctx, nctx;
   logic    emit, adv, in_range, s1_take;
   rsp_type srsp;

   // stage 1 may step when the output register can take its result
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign in_range  = (32'(req_data.connection) < CONNECTIONS);
   assign s1_take   = s1_vld_ff && adv;

   mcfd_ctx_mem u_mem (
      .clock(clock), .reset(reset),
      .rd_en(req_valid && req_ready),
      .rd_addr(req_data.connection[CONN_W-1:0]),
      .rd_data(rd_data),
      .wr_en(s1_take),
      .wr_addr(s1_req_ff.connection[CONN_W-1:0]),
      .wr_data(nctx)
   );

   // forward the last write when the read raced it
   assign ctx = (fwd_vld_ff && fwd_addr_ff == s1_req_ff.connection[CONN_W-1:0]) ?
                fwd_ff : rd_data;

   mcfd_step u_step (.ireq(s1_req_ff), .ctx(ctx), .nctx(nctx), .emit(emit), .rsp(srsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_vld_ff  <= req_valid && in_range;
            out_vld_ff <= s1_vld_ff && emit;
            // forward only if the write lands in the cycle of the new read
            fwd_vld_ff <= s1_vld_ff && req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff   <= req_data;
         out_ff      <= srsp;
         fwd_ff      <= nctx;
         fwd_addr_ff <= s1_req_ff.connection[CONN_W-1:0];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_close_kind: assert property (@(posedge clock) disable iff (reset)
      s1_take && s1_req_ff.command |-> emit && srsp.result_kind == KIND_CLOSE)
      else $error("close did not produce a notice");
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_frame |-> !rsp_data.frame_status)
      else $error("status without last");
endmodule

### tb/sv/tb_multi_connection_frame_deframer.sv
// Testbench for multi_connection_frame_deframer: per-connection deframing of
// plain and MY frames, close notices, checked against an internal predictor.
// Depends on mcfd_pkg and the RTL of the block.
`timescale 1ns / 1ps

class deframe_scoreboard;
   // predictor state, one entry per connection
   logic [3:0]  hdr_idx     [16];
   logic [7:0]  held_byte   [16];
   logic        is_my       [16];
   logic [15:0] remaining   [16];
   logic [15:0] frame_len   [16];
   logic [7:0]  sum         [16];
   logic [7:0]  chk_byte    [16];
   logic [15:0] cmd         [16];
   logic [7:0]  ver         [16];
   logic [7:0]  subver      [16];
   mcfd_pkg::rsp_type pending_results[$];
   int errors;
   int payload_seen, empty_seen, close_seen, bad_status_seen;

   function new();
      errors = 0;
      payload_seen = 0;
      empty_seen = 0;
      close_seen = 0;
      bad_status_seen = 0;
      for (int c = 0; c < 16; c++) clear_conn(c);
   endfunction

   function void clear_conn(int c);
      hdr_idx[c] = '0;
      held_byte[c] = '0;
      is_my[c] = 1'b0;
      remaining[c] = '0;
      frame_len[c] = '0;
      sum[c] = '0;
      chk_byte[c] = '0;
      cmd[c] = '0;
      ver[c] = '0;
      subver[c] = '0;
   endfunction

   function mcfd_pkg::rsp_type make_rsp(mcfd_pkg::kind_type kind, int c, logic [7:0] b,
                                        logic first, logic last, logic status);
      mcfd_pkg::rsp_type r;
      r.result_kind = kind;
      r.out_connection = c[3:0];
      r.payload_byte = b;
      r.first_of_frame = first;
      r.last_of_frame = last;
      r.frame_status = status;
      r.framed_format = is_my[c];
      r.command_code = cmd[c];
      r.version_value = ver[c];
      r.subversion_value = subver[c];
      r.frame_length = frame_len[c];
      return r;
   endfunction

   function void header_done(int c);
      hdr_idx[c] = '0;
      sum[c] = '0;
      remaining[c] = frame_len[c];
      if (frame_len[c] == 16'd0)
         pending_results.push_back(make_rsp(mcfd_pkg::KIND_EMPTY, c, 8'd0, 1'b1, 1'b1,
                                            is_my[c] && chk_byte[c] != 8'd0));
   endfunction

   // Predict the result, if any, of one accepted input transfer.
   function void note_input(mcfd_pkg::req_type rq);
      int c;
      logic [7:0] b, v;
      logic enc, first, last, status;
      c = rq.connection;
      b = rq.data_byte;
      if (c >= mcfd_pkg::CONNECTIONS) return;
      if (rq.command) begin
         clear_conn(c);
         pending_results.push_back(make_rsp(mcfd_pkg::KIND_CLOSE, c, 8'd0, 1'b0, 1'b0, 1'b0));
         return;
      end
      if (remaining[c] != 16'd0) begin
         enc = is_my[c] && chk_byte[c] != 8'd0;
         first = remaining[c] == frame_len[c];
         v = b;
         status = 1'b0;
         if (enc) begin
            v = mcfd_pkg::subst(b);
            sum[c] = sum[c] + v;
         end
         remaining[c] = remaining[c] - 16'd1;
         last = remaining[c] == 16'd0;
         if (last && enc) status = (sum[c] + chk_byte[c]) != 8'd0;
         pending_results.push_back(make_rsp(mcfd_pkg::KIND_PAYLOAD, c, v, first, last, status));
         if (last) sum[c] = '0;
         return;
      end
      case (hdr_idx[c])
         4'd0: begin
            held_byte[c] = b;
            hdr_idx[c] = 4'd1;
         end
         4'd1: begin
            if ((held_byte[c] == "M" || held_byte[c] == "m") && (b == "Y" || b == "y")) begin
               is_my[c] = 1'b1;
               hdr_idx[c] = 4'd2;
            end else begin
               is_my[c] = 1'b0;
               cmd[c] = '0;
               ver[c] = '0;
               subver[c] = '0;
               chk_byte[c] = '0;
               frame_len[c] = {held_byte[c], b};
               header_done(c);
            end
         end
         default: begin
            case (hdr_idx[c])
               4'd2: cmd[c] = {8'd0, b};
               4'd3: cmd[c][15:8] = b;
               4'd4: ver[c] = b;
               4'd5: subver[c] = b;
               4'd6: frame_len[c] = {8'd0, b};
               4'd7: frame_len[c][15:8] = b;
               4'd8: chk_byte[c] = b;
               default: ;
            endcase
            if (hdr_idx[c] == mcfd_pkg::HDR_LAST) header_done(c);
            else hdr_idx[c] = hdr_idx[c] + 4'd1;
         end
      endcase
   endfunction

   function void check_result(mcfd_pkg::rsp_type got);
      mcfd_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result: %p", got);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      case (got.result_kind)
         mcfd_pkg::KIND_PAYLOAD: payload_seen++;
         mcfd_pkg::KIND_EMPTY: empty_seen++;
         default: close_seen++;
      endcase
      if (got.frame_status) bad_status_seen++;
      if (got.result_kind !== want.result_kind) begin
         $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind); errors++;
      end
      if (got.out_connection !== want.out_connection) begin
         $error("out_connection exp %0d got %0d", want.out_connection, got.out_connection);
         errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
         $error("payload_byte exp %h got %h", want.payload_byte, got.payload_byte); errors++;
      end
      if (got.first_of_frame !== want.first_of_frame) begin
         $error("first_of_frame exp %b got %b", want.first_of_frame, got.first_of_frame);
         errors++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
         $error("last_of_frame exp %b got %b", want.last_of_frame, got.last_of_frame); errors++;
      end
      if (got.frame_status !== want.frame_status) begin
         $error("frame_status exp %b got %b", want.frame_status, got.frame_status); errors++;
      end
      if (got.framed_format !== want.framed_format) begin
         $error("framed_format exp %b got %b", want.framed_format, got.framed_format); errors++;
      end
      if (got.command_code !== want.command_code) begin
         $error("command_code exp %h got %h", want.command_code, got.command_code); errors++;
      end
      if (got.version_value !== want.version_value) begin
         $error("version_value exp %0d got %0d", want.version_value, got.version_value);
         errors++;
      end
      if (got.subversion_value !== want.subversion_value) begin
         $error("subversion_value exp %0d got %0d", want.subversion_value,
                got.subversion_value);
         errors++;
      end
      if (got.frame_length !== want.frame_length) begin
         $error("frame_length exp %0d got %0d", want.frame_length, got.frame_length); errors++;
      end
   endfunction
endclass

module tb_multi_connection_frame_deframer;
   import mcfd_pkg::*;

   localparam int TIMEOUT_CYCLES = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   deframe_scoreboard frames = new();
   int cycle_count = 0;
   int items_sent = 0;
   bit hold_off_rsp = 1'b0;   // long receiver stall requested by the sender
   bit sending_done = 1'b0;

   always #5 clock = ~clock;

   multi_connection_frame_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Transfers are seen at the rising edge; predictor and checker run there.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) frames.note_input(req_data);
      if (!reset && rsp_valid && rsp_ready) frames.check_result(rsp_data);
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random ready with short and long stalls; one long hold-off on request.
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off_rsp = 1'b0;
         end
         g = gap_len();
         if (g > 0 && cycle_count % 700 < 500) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Offer one item and hold it until accepted; then maybe idle.
   task automatic send_item(input logic cmd, input int conn, input int b, input bit idle);
      int g;
      req_data <= '{command: cmd, connection: conn[3:0], data_byte: b[7:0]};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      g = idle ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic send_plain(input int conn, input int len, input bit idle);
      send_item(1'b0, conn, len >> 8, idle);
      send_item(1'b0, conn, len & 8'hFF, idle);
      for (int i = 0; i < len; i++) send_item(1'b0, conn, $urandom_range(0, 255), idle);
   endtask

   // MY header: case of the tag, cmd, version, subversion, length, check code, filler.
   task automatic send_my(input int conn, input int len, input int code, input bit idle);
      int hdr[13];
      hdr[0] = $urandom_range(0, 1) ? "M" : "m";
      hdr[1] = $urandom_range(0, 1) ? "Y" : "y";
      hdr[2] = $urandom_range(0, 255);
      hdr[3] = $urandom_range(0, 255);
      hdr[4] = $urandom_range(0, 255);
      hdr[5] = $urandom_range(0, 255);
      hdr[6] = len & 8'hFF;
      hdr[7] = len >> 8;
      hdr[8] = code;
      for (int i = 9; i < 13; i++) hdr[i] = $urandom_range(0, 255);
      for (int i = 0; i < 13; i++) send_item(1'b0, conn, hdr[i], idle);
      for (int i = 0; i < len; i++) send_item(1'b0, conn, $urandom_range(0, 255), idle);
   endtask

   task automatic idle_until_drained();
      req_valid <= 1'b0;
      while (frames.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int pick, conn;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: both formats, empty frames, zero and nonzero check code, a broken
      // "MX" tag, close on idle and mid-frame.
      send_item(1'b1, 0, 8'hFF, 1'b0);
      send_plain(15, 0, 1'b0);
      send_plain(3, 2, 1'b0);
      send_my(5, 0, 0, 1'b0);
      send_my(6, 0, 8'hA5, 1'b0);
      send_item(1'b0, 7, "M", 1'b0);
      send_item(1'b0, 7, "X", 1'b0);
      send_item(1'b0, 7, 8'hFF, 1'b0);
      send_item(1'b1, 7, 8'h00, 1'b0);
      send_item(1'b1, 15, 8'h55, 1'b0);
      idle_until_drained();

      // Long receiver hold-off while the sender keeps offering: block fills up.
      hold_off_rsp = 1'b1;
      send_my(2, 20, 8'h3C, 1'b0);
      send_my(9, 6, 0, 1'b0);
      idle_until_drained();

      // Random part: mostly well-formed frames interleaved over connections.
      while (items_sent < 1150) begin
         pick = $urandom_range(0, 99);
         conn = $urandom_range(0, 15);
         if (pick < 35)
            send_plain(conn, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12), 1'b1);
         else if (pick < 65)
            send_my(conn, $urandom_range(0, 10), $urandom_range(1, 255), 1'b1);
         else if (pick < 75)
            send_my(conn, $urandom_range(0, 6), 0, 1'b1);
         else if (pick < 82)
            send_item(1'b1, conn, $urandom_range(0, 255), 1'b1);
         else
            send_item(1'b0, conn, $urandom_range(0, 255), 1'b1);
         if ($urandom_range(0, 60) == 0) idle_until_drained();
      end
      // Close every connection so that half-built frames are cleaned up.
      for (int c = 0; c < 16; c++) send_item(1'b1, c, 0, 1'b1);
      req_valid <= 1'b0;

      while (frames.pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d items; checked %0d payload bytes, %0d empty frames, %0d closes",
               items_sent, frames.payload_seen, frames.empty_seen, frames.close_seen);
      $display("Results with checksum error flagged: %0d", frames.bad_status_seen);
      if (frames.errors == 0 && frames.pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

### sim.f
src/mcfd_pkg.sv
src/mcfd_ctx_mem.sv
src/mcfd_step.sv
src/multi_connection_frame_deframer.sv
tb/sv/tb_multi_connection_frame_deframer.sv
